// ----- design/qbal_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qbal_pkg
// Shared types and constants for the quadratic Bezier evaluator with
// chord-sum arc length.
// ----------------------------------------------------------------------------
package qbal_pkg;

    localparam int COORD_BITS = 16;
    localparam int T_BITS     = 17;
    localparam int DIST_BITS  = 18;
    localparam int LEN_BITS   = 18;
    localparam int QUOT_BITS  = 18;

    localparam logic [T_BITS-1:0]    T_ONE   = T_BITS'(65536);
    localparam logic [LEN_BITS-1:0]  LEN_MAX = '1;
    localparam logic [QUOT_BITS-1:0] QUOT_MAX = '1;

    // exact blend sum: coordinate times 2^32 plus headroom for the increments
    localparam int ACC_BITS  = COORD_BITS + 36;
    localparam int SQ_STEPS  = COORD_BITS + 1;
    localparam int SQ_VBITS  = 2 * SQ_STEPS;
    localparam int SQ_RBITS  = SQ_STEPS + 3;
    localparam int SUM_BITS  = (COORD_BITS + 2 > LEN_BITS + 1) ? COORD_BITS + 2 : LEN_BITS + 1;
    localparam int DIV_LAT   = QUOT_BITS + 1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] mid_x;
        logic signed [COORD_BITS-1:0] mid_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic        [T_BITS-1:0]     param_t;
        logic        [DIST_BITS-1:0]  travelled;
    } item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic        [LEN_BITS-1:0]   curve_length;
        logic        [QUOT_BITS-1:0]  t_at_distance;
        logic                         length_zero;
    } result_t;

    typedef struct packed {
        logic signed [COORD_BITS:0]   ax;
        logic signed [COORD_BITS+1:0] bx;
        logic signed [COORD_BITS:0]   ay;
        logic signed [COORD_BITS+1:0] by;
        logic signed [ACC_BITS-1:0]   sx;
        logic signed [ACC_BITS-1:0]   sy;
    } curve_t;

endpackage

`default_nettype wire

// ----- design/qbal_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qbal_cell
// One sample of the chord chain: steps the blend sum to the next sample
// parameter, takes the chord to the previous sample through a pipelined
// square root and adds it to the running length.
// ----------------------------------------------------------------------------
module qbal_cell #(
    parameter int K        = 1,
    parameter int SEGMENTS = 50
) (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire qbal_pkg::curve_t                cur_in,
    input  wire logic [qbal_pkg::LEN_BITS-1:0]   sum_in,
    output qbal_pkg::curve_t                     cur_out,
    output logic [qbal_pkg::LEN_BITS-1:0]        sum_out
);
    import qbal_pkg::*;

    localparam longint TK  = (longint'(K) * 64'sd65536) / SEGMENTS;
    localparam longint TP  = (longint'(K - 1) * 64'sd65536) / SEGMENTS;
    localparam longint DT  = TK - TP;
    localparam longint DSQ = TK * TK - TP * TP;

    localparam logic signed [17:0] DT_C  = 18'(DT);
    localparam logic signed [33:0] DSQ_C = 34'(DSQ);

    curve_t                  cur_reg;
    logic [COORD_BITS-1:0]   prev_x_reg, prev_y_reg;
    logic [SQ_VBITS-1:0]     vsq_reg;
    logic [SQ_RBITS-1:0]     rem_reg  [SQ_STEPS];
    logic [SQ_STEPS-1:0]     root_reg [SQ_STEPS];
    logic [SQ_VBITS-1:0]     val_reg  [SQ_STEPS];
    logic [LEN_BITS-1:0]     sum_reg;

    logic signed [COORD_BITS+18:0] pax, pay;
    logic signed [ACC_BITS-1:0]    pbx, pby;
    curve_t                        cur_next;
    logic [COORD_BITS-1:0]         px, py, dx, dy;
    logic [SQ_VBITS-1:0]           vsq_next;
    logic [SUM_BITS-1:0]           sum_wide;
    logic [LEN_BITS-1:0]           sum_next;

    always_comb
    begin
        pax = cur_in.ax * DT_C;
        pay = cur_in.ay * DT_C;
        pbx = ACC_BITS'(cur_in.bx) * ACC_BITS'(DSQ_C);
        pby = ACC_BITS'(cur_in.by) * ACC_BITS'(DSQ_C);
        cur_next    = cur_in;
        cur_next.sx = cur_in.sx + (ACC_BITS'(pax) <<< 17) + pbx;
        cur_next.sy = cur_in.sy + (ACC_BITS'(pay) <<< 17) + pby;
    end

    always_comb
    begin
        px = cur_reg.sx[COORD_BITS+31:32];
        py = cur_reg.sy[COORD_BITS+31:32];
        dx = (px > prev_x_reg) ? px - prev_x_reg : prev_x_reg - px;
        dy = (py > prev_y_reg) ? py - prev_y_reg : prev_y_reg - py;
        vsq_next = SQ_VBITS'(dx * dx) + SQ_VBITS'(dy * dy);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cur_reg    <= cur_next;
            prev_x_reg <= cur_in.sx[COORD_BITS+31:32];
            prev_y_reg <= cur_in.sy[COORD_BITS+31:32];
            vsq_reg    <= vsq_next;
        end
    end

    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_sqrt
        logic [SQ_RBITS-1:0] rem_prev, rem2, trial, rem_next;
        logic [SQ_STEPS-1:0] root_prev, root_next;
        logic [SQ_VBITS-1:0] val_prev;
        logic                ge;

        if (i == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign val_prev  = vsq_reg;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[i-1];
            assign root_prev = root_reg[i-1];
            assign val_prev  = val_reg[i-1];
        end

        always_comb
        begin
            rem2      = {rem_prev[SQ_RBITS-3:0], val_prev[SQ_VBITS-1:SQ_VBITS-2]};
            trial     = SQ_RBITS'({root_prev, 2'b01});
            ge        = (rem2 >= trial);
            rem_next  = ge ? rem2 - trial : rem2;
            root_next = {root_prev[SQ_STEPS-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                val_reg[i]  <= val_prev << 2;
            end
        end
    end

    always_comb
    begin
        sum_wide = SUM_BITS'(sum_in) + SUM_BITS'(root_reg[SQ_STEPS-1]);
        sum_next = (sum_wide > SUM_BITS'(LEN_MAX)) ? LEN_MAX : sum_wide[LEN_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign cur_out = cur_reg;
    assign sum_out = sum_reg;

endmodule

`default_nettype wire

// ----- design/qbal_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qbal_div
// Pipelined restoring divider: travelled * 2^16 / length, one quotient bit
// per stage, with saturation and the zero-length case.
// ----------------------------------------------------------------------------
module qbal_div (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic [qbal_pkg::LEN_BITS-1:0]    len,
    input  wire logic [qbal_pkg::DIST_BITS-1:0]   travel,
    output logic [qbal_pkg::QUOT_BITS-1:0]        quot,
    output logic [qbal_pkg::LEN_BITS-1:0]         len_out,
    output logic                                  zero_out
);
    import qbal_pkg::*;

    localparam int RW = LEN_BITS + 1;

    logic [LEN_BITS-1:0]  len_reg  [DIV_LAT];
    logic                 zero_reg [DIV_LAT];
    logic                 sat_reg  [DIV_LAT];
    logic [1:0]           low_reg  [DIV_LAT];
    logic [RW-1:0]        rem_reg  [DIV_LAT];
    logic [QUOT_BITS-1:0] q_reg    [DIV_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg[0]  <= len;
            zero_reg[0] <= (len == '0);
            sat_reg[0]  <= ({2'b00, travel} >= {len, 2'b00});
            low_reg[0]  <= travel[1:0];
            rem_reg[0]  <= RW'(travel[DIST_BITS-1:2]);
            q_reg[0]    <= '0;
        end
    end

    for (genvar j = 1; j < DIV_LAT; j++)
    begin : g_step
        logic          bit_in, ge;
        logic [RW:0]   rem2;
        logic [RW-1:0] rem_next;

        always_comb
        begin
            bit_in   = (j == 1) ? low_reg[j-1][1] : ((j == 2) ? low_reg[j-1][0] : 1'b0);
            rem2     = {rem_reg[j-1], bit_in};
            ge       = (rem2 >= (RW+1)'(len_reg[j-1]));
            rem_next = ge ? RW'(rem2 - (RW+1)'(len_reg[j-1])) : RW'(rem2);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                len_reg[j]  <= len_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
                sat_reg[j]  <= sat_reg[j-1];
                low_reg[j]  <= low_reg[j-1];
                rem_reg[j]  <= rem_next;
                q_reg[j]    <= {q_reg[j-1][QUOT_BITS-2:0], ge};
            end
        end
    end

    always_comb
    begin
        if (zero_reg[DIV_LAT-1])
            quot = '0;
        else if (sat_reg[DIV_LAT-1])
            quot = QUOT_MAX;
        else
            quot = q_reg[DIV_LAT-1];
        len_out  = len_reg[DIV_LAT-1];
        zero_out = zero_reg[DIV_LAT-1];
    end

endmodule

`default_nettype wire

// ----- design/quadratic_bezier_eval_arc_length.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_bezier_eval_arc_length
// Evaluates a quadratic Bezier curve at param_t and measures its length as
// the sum of SEGMENTS chords; also divides travelled by that length.
//
// Usage:
//   item channel   : item_valid / item_stall / item carry one curve each.
//   result channel : result_valid / result_stall / result, one per item.
//   Throughput is one transaction per cycle while item_stall is low. An
//   accepted transaction passes the front register, SEGMENTS chain cells,
//   a squaring stage, a 17-stage square root and the length adder, a
//   19-stage divider, then the output register before result_valid rises.
//   The pipeline advances while the output register is empty, is being
//   taken, or no result is arriving; otherwise item_stall is raised and
//   everything holds. A stalled result keeps its value.
//   Reset clears all valid flags; no result is pending after reset and the
//   block takes an item in the first cycle.
// ----------------------------------------------------------------------------
module quadratic_bezier_eval_arc_length #(
    parameter int SEGMENTS = 50
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire qbal_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output qbal_pkg::result_t      result
);
    import qbal_pkg::*;

    localparam int SUM_ST = SEGMENTS + SQ_STEPS + 3;
    localparam int DEPTH  = SUM_ST + DIV_LAT;
    localparam int PD     = DEPTH - 4;
    localparam int DD     = SUM_ST - 1;
    localparam logic [COORD_BITS-1:0] SIGN_BIT = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic                  adv;
    logic [DEPTH:1]        vld_reg, vld_next;
    logic                  result_valid_reg, result_valid_next;
    result_t               result_reg;

    logic [COORD_BITS-1:0] c0x, c1x, c2x, c0y, c1y, c2y;
    curve_t                cur_next, cur1_reg;
    logic [T_BITS-1:0]     t_sat, t1_reg, t2_reg;
    logic [DIST_BITS-1:0]  dist1_reg;

    logic signed [COORD_BITS+18:0] pax2_reg, pay2_reg, pax3_reg, pay3_reg;
    logic signed [COORD_BITS+19:0] pbx2_reg, pby2_reg;
    logic signed [ACC_BITS-1:0]    pbx3_reg, pby3_reg;
    logic [COORD_BITS-1:0]         c0x2_reg, c0y2_reg, c0x3_reg, c0y3_reg;
    logic signed [ACC_BITS-1:0]    ex, ey;
    logic [COORD_BITS-1:0]         px4_reg, py4_reg;

    logic [COORD_BITS-1:0] pdx_reg [PD];
    logic [COORD_BITS-1:0] pdy_reg [PD];
    logic [DIST_BITS-1:0]  dd_reg  [DD];

    curve_t                cur_chain [SEGMENTS+1];
    logic [LEN_BITS-1:0]   sum_chain [SEGMENTS+1];

    logic [QUOT_BITS-1:0]  quot;
    logic [LEN_BITS-1:0]   len_out;
    logic                  zero_out;

    assign adv        = !result_valid_reg || !result_stall || !vld_reg[DEPTH];
    assign item_stall = !adv;

    always_comb
    begin
        c0x = item.start_x ^ SIGN_BIT;
        c1x = item.mid_x   ^ SIGN_BIT;
        c2x = item.end_x   ^ SIGN_BIT;
        c0y = item.start_y ^ SIGN_BIT;
        c1y = item.mid_y   ^ SIGN_BIT;
        c2y = item.end_y   ^ SIGN_BIT;
        cur_next.ax = $signed({1'b0, c1x}) - $signed({1'b0, c0x});
        cur_next.ay = $signed({1'b0, c1y}) - $signed({1'b0, c0y});
        cur_next.bx = $signed({2'b00, c0x}) - $signed({1'b0, c1x, 1'b0})
                    + $signed({2'b00, c2x});
        cur_next.by = $signed({2'b00, c0y}) - $signed({1'b0, c1y, 1'b0})
                    + $signed({2'b00, c2y});
        cur_next.sx = $signed(ACC_BITS'({c0x, 32'd0}));
        cur_next.sy = $signed(ACC_BITS'({c0y, 32'd0}));
        t_sat = (item.param_t > T_ONE) ? T_ONE : item.param_t;
    end

    always_comb
    begin
        ex = $signed(ACC_BITS'({c0x3_reg, 32'd0})) + (ACC_BITS'(pax3_reg) <<< 17) + pbx3_reg;
        ey = $signed(ACC_BITS'({c0y3_reg, 32'd0})) + (ACC_BITS'(pay3_reg) <<< 17) + pby3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cur1_reg  <= cur_next;
            t1_reg    <= t_sat;
            dist1_reg <= item.travelled;

            pax2_reg <= cur1_reg.ax * $signed({1'b0, t1_reg});
            pay2_reg <= cur1_reg.ay * $signed({1'b0, t1_reg});
            pbx2_reg <= cur1_reg.bx * $signed({1'b0, t1_reg});
            pby2_reg <= cur1_reg.by * $signed({1'b0, t1_reg});
            c0x2_reg <= cur1_reg.sx[COORD_BITS+31:32];
            c0y2_reg <= cur1_reg.sy[COORD_BITS+31:32];
            t2_reg   <= t1_reg;

            pax3_reg <= pax2_reg;
            pay3_reg <= pay2_reg;
            pbx3_reg <= ACC_BITS'(pbx2_reg) * $signed(ACC_BITS'(t2_reg));
            pby3_reg <= ACC_BITS'(pby2_reg) * $signed(ACC_BITS'(t2_reg));
            c0x3_reg <= c0x2_reg;
            c0y3_reg <= c0y2_reg;

            px4_reg <= ex[COORD_BITS+31:32];
            py4_reg <= ey[COORD_BITS+31:32];

            pdx_reg[0] <= px4_reg;
            pdy_reg[0] <= py4_reg;
            for (int j = 1; j < PD; j++)
            begin
                pdx_reg[j] <= pdx_reg[j-1];
                pdy_reg[j] <= pdy_reg[j-1];
            end

            dd_reg[0] <= dist1_reg;
            for (int j = 1; j < DD; j++)
            begin
                dd_reg[j] <= dd_reg[j-1];
            end
        end
    end

    assign cur_chain[0] = cur1_reg;
    assign sum_chain[0] = '0;

    for (genvar k = 1; k <= SEGMENTS; k++)
    begin : g_cell
        qbal_cell #(
            .K        (k),
            .SEGMENTS (SEGMENTS)
        ) u_cell (
            .clk     (clk),
            .en      (adv),
            .cur_in  (cur_chain[k-1]),
            .sum_in  (sum_chain[k-1]),
            .cur_out (cur_chain[k]),
            .sum_out (sum_chain[k])
        );
    end

    qbal_div u_div (
        .clk      (clk),
        .en       (adv),
        .len      (sum_chain[SEGMENTS]),
        .travel   (dd_reg[DD-1]),
        .quot     (quot),
        .len_out  (len_out),
        .zero_out (zero_out)
    );

    always_comb
    begin
        vld_next = vld_reg;
        if (adv)
            vld_next = {vld_reg[DEPTH-1:1], item_valid};
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;
        if (adv && vld_reg[DEPTH])
            result_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg          <= vld_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && vld_reg[DEPTH])
        begin
            result_reg.point_x       <= pdx_reg[PD-1] ^ SIGN_BIT;
            result_reg.point_y       <= pdy_reg[PD-1] ^ SIGN_BIT;
            result_reg.curve_length  <= len_out;
            result_reg.t_at_distance <= quot;
            result_reg.length_zero   <= zero_out;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> vld_reg[1])
        else $error("accepted transaction did not enter the pipeline");

    a_rise_from_tail: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(vld_reg[DEPTH]))
        else $error("result appeared without a transaction at the tail");

    a_zero_quot: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.length_zero) |-> (result.t_at_distance == '0))
        else $error("zero length with nonzero t_at_distance");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.length_zero == (result.curve_length == '0)))
        else $error("length_zero disagrees with curve_length");

endmodule

`default_nettype wire
